[src/fcgi_pkg.sv]
package fcgi_pkg;

  // Record types and flags
  localparam logic [7:0] RecBegin  = 8'd1;
  localparam logic [7:0] RecParams = 8'd4;
  localparam logic [7:0] RecStdin  = 8'd5;
  localparam int unsigned KeepConnBit = 0;
  localparam int unsigned LongLenBit  = 7;

  typedef enum logic [2:0] {
    KIND_PAIR_HDR = 3'd0,
    KIND_NAME     = 3'd1,
    KIND_VALUE    = 3'd2,
    KIND_BODY     = 3'd3,
    KIND_PEND     = 3'd4,
    KIND_REQ_DONE = 3'd5
  } kind_e;

  // One result item (93 bits); kind goes out on tuser, last_of_field on tlast
  typedef struct packed {
    logic        truncated;
    logic        close_conn;
    logic        keep_alive_out;
    logic [15:0] req_id;
    logic        last_of_field;
    logic [30:0] value_length;
    logic [30:0] name_length;
    logic [7:0]  data_byte;
    kind_e       kind;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);
  // Fields left for tdata: 89 bits, padded to 96
  localparam int unsigned TDataW = ResultW - $bits(kind_e) - 1;
  localparam int unsigned OutDataW = ((TDataW + 7) / 8) * 8;

endpackage

[src/fastcgi_record_deframer.sv]
// FastCGI record deframer.
// Input: s_axis_* carries one connection byte per item (tdata[7:0] = in_byte).
// Output: m_axis_* carries one decoded result per item: pair header, name,
// value or body byte, params end, or request done. tuser holds the kind,
// tlast marks the final byte of a name or value, tdata the other fields.
// Throughput: one byte per cycle sustained while the queue has space;
// bytes that produce no result (header, padding, skipped records) are
// still taken at one per cycle. A result is held in the decoder's output
// register, then passes through the two-entry queue to the output port.
// When the receiver stalls the queue fills, the decoder holds its register
// and s_axis_tready drops until space opens; nothing is lost.
// Reset clears all framing state; the first byte after reset starts a
// record header. After a request done without keep-alive the block stays
// closed: bytes are accepted and dropped until the next reset.
module fastcgi_record_deframer import fcgi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] in_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] data_byte, [38:8] name_length, [69:39] value_length,
  // [85:70] req_id, [86] keep_alive_out, [87] close_conn, [88] truncated,
  // [95:89] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [2:0]          m_axis_tuser,  // [2:0] kind
  output logic                m_axis_tlast   // last_of_field
);

  logic    f_valid, q_ready;
  result_t f_res, q_res;

  fcgi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(s_axis_tvalid),
    .byte_ready_o(s_axis_tready),
    .byte_i      (s_axis_tdata),
    .res_valid_o (f_valid),
    .res_ready_i (q_ready),
    .res_o       (f_res)
  );

  fcgi_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(f_valid),
    .wr_ready_o(q_ready),
    .wr_data_i (f_res),
    .rd_valid_o(m_axis_tvalid),
    .rd_ready_i(m_axis_tready),
    .rd_data_o (q_res)
  );

  // Output packing
  assign m_axis_tuser = q_res.kind;
  assign m_axis_tlast = q_res.last_of_field;
  assign m_axis_tdata = {{(OutDataW - TDataW){1'b0}},
                         q_res.truncated, q_res.close_conn, q_res.keep_alive_out,
                         q_res.req_id, q_res.value_length, q_res.name_length,
                         q_res.data_byte};

endmodule

[src/fcgi_front.sv]
// Front end: record framing and pair decoding, one byte per cycle while res_ready_i is high.
module fcgi_front import fcgi_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    byte_valid_i,
  output logic    byte_ready_o,
  input  logic [7:0] byte_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  typedef enum logic [1:0] {
    PH_NLEN, PH_VLEN, PH_NAME, PH_VALUE
  } phase_e;

  logic [2:0]  hdr_idx_q, hdr_idx_d;
  logic [7:0]  rkind_q, rkind_d;
  logic [15:0] rid_q, rid_d;
  logic [15:0] cleft_q, cleft_d;
  logic [15:0] coff_q, coff_d;
  logic [7:0]  pad_q, pad_d;
  logic        ka_q, ka_d;
  logic        closed_q, closed_d;
  logic        body_q, body_d;
  phase_e      ph_q, ph_d;
  logic [1:0]  lbi_q, lbi_d;
  logic [31:0] acc_q, acc_d;
  logic [30:0] nleft_q, nleft_d;
  logic [30:0] vleft_q, vleft_d;

  logic    fire;
  logic    emit;
  result_t res;
  logic    len_done;
  logic [30:0] len_val;
  logic [31:0] acc_sh;

  assign byte_ready_o = res_ready_i;
  assign fire = byte_valid_i && byte_ready_o;
  assign acc_sh = {acc_q[23:0], byte_i};

  // Length field decoder (1 or 4 bytes)
  always_comb begin
    len_done = 1'b0;
    len_val  = '0;
    lbi_d    = lbi_q;
    acc_d    = acc_q;
    if (lbi_q == 2'd0) begin
      if (!byte_i[LongLenBit]) begin
        len_done = 1'b1;
        len_val  = {23'd0, byte_i};
      end else begin
        acc_d = {24'd0, byte_i};
        lbi_d = 2'd1;
      end
    end else begin
      acc_d = acc_sh;
      if (lbi_q == 2'd3) begin
        lbi_d    = 2'd0;
        len_done = 1'b1;
        len_val  = acc_sh[30:0];
      end else begin
        lbi_d = lbi_q + 2'd1;
      end
    end
  end

  // Main framing and pair logic
  always_comb begin
    logic [30:0] dec;
    logic [15:0] cl_n;
    logic [7:0]  pd_n;
    hdr_idx_d = hdr_idx_q; rkind_d = rkind_q; rid_d = rid_q;
    cleft_d = cleft_q; coff_d = coff_q; pad_d = pad_q; ka_d = ka_q;
    closed_d = closed_q; body_d = body_q; ph_d = ph_q;
    nleft_d = nleft_q; vleft_d = vleft_q;
    emit = 1'b0;
    res = '0;
    dec = '0;
    cl_n = cleft_q;
    pd_n = pad_q;
    if (!closed_q && !body_q) begin
      unique case (hdr_idx_q)
        3'd1: rkind_d = byte_i;
        3'd2: rid_d = {byte_i, rid_q[7:0]};
        3'd3: rid_d = {rid_q[15:8], byte_i};
        3'd4: cleft_d = {byte_i, cleft_q[7:0]};
        3'd5: cleft_d = {cleft_q[15:8], byte_i};
        3'd6: pad_d = byte_i;
        default: ;
      endcase
      hdr_idx_d = hdr_idx_q + 3'd1;
      if (hdr_idx_q == 3'd7) begin
        coff_d = '0;
        body_d = (cleft_q != 0) || (pad_q != 0);
        res.req_id = rid_q;
        if (rkind_q == RecBegin) begin
          ka_d = 1'b0;
          ph_d = PH_NLEN; nleft_d = '0; vleft_d = '0;
        end else if (cleft_q == 0 && rkind_q == RecParams) begin
          emit = 1'b1;
          res.kind = KIND_PEND;
          res.truncated = (ph_q != PH_NLEN) || (lbi_q != 2'd0);
          ph_d = PH_NLEN; nleft_d = '0; vleft_d = '0;
        end else if (cleft_q == 0 && rkind_q == RecStdin) begin
          emit = 1'b1;
          res.kind = KIND_REQ_DONE;
          res.keep_alive_out = ka_q;
          res.close_conn = !ka_q;
          closed_d = !ka_q;
          ph_d = PH_NLEN; nleft_d = '0; vleft_d = '0;
        end
      end
    end else if (!closed_q) begin
      res.req_id = rid_q;
      if (cleft_q != 0) begin
        if (rkind_q == RecBegin) begin
          if (coff_q == 16'd2) ka_d = byte_i[KeepConnBit];
        end else if (rkind_q == RecParams) begin
          unique case (ph_q)
            PH_NLEN: if (len_done) begin
              nleft_d = len_val;
              ph_d = PH_VLEN;
            end
            PH_VLEN: if (len_done) begin
              vleft_d = len_val;
              ph_d = (nleft_q != 0) ? PH_NAME : ((len_val != 0) ? PH_VALUE : PH_NLEN);
              emit = 1'b1;
              res.kind = KIND_PAIR_HDR;
              res.name_length = nleft_q;
              res.value_length = len_val;
            end
            PH_NAME: begin
              dec = nleft_q - 31'd1;
              nleft_d = dec;
              emit = 1'b1;
              res.kind = KIND_NAME;
              res.data_byte = byte_i;
              res.last_of_field = (dec == 0);
              if (dec == 0) ph_d = (vleft_q != 0) ? PH_VALUE : PH_NLEN;
            end
            default: begin
              dec = vleft_q - 31'd1;
              vleft_d = dec;
              emit = 1'b1;
              res.kind = KIND_VALUE;
              res.data_byte = byte_i;
              res.last_of_field = (dec == 0);
              if (dec == 0) ph_d = PH_NLEN;
            end
          endcase
        end else if (rkind_q == RecStdin) begin
          emit = 1'b1;
          res.kind = KIND_BODY;
          res.data_byte = byte_i;
        end
        cl_n = cleft_q - 16'd1;
        cleft_d = cl_n;
        coff_d = coff_q + 16'd1;
      end else if (pad_q != 0) begin
        pd_n = pad_q - 8'd1;
        pad_d = pd_n;
      end
      if (cl_n == 0 && pd_n == 0) body_d = 1'b0;
    end
  end

  // Length decoder only advances on pair length phases
  logic len_upd;
  assign len_upd = !closed_q && body_q && cleft_q != 0 && rkind_q == RecParams &&
                   (ph_q == PH_NLEN || ph_q == PH_VLEN);
  logic pair_clr;
  assign pair_clr = !closed_q && !body_q && hdr_idx_q == 3'd7 &&
                    (rkind_q == RecBegin ||
                     (cleft_q == 0 && (rkind_q == RecParams || rkind_q == RecStdin)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_idx_q <= '0; rkind_q <= '0; rid_q <= '0; cleft_q <= '0;
      coff_q <= '0; pad_q <= '0; ka_q <= 1'b0; closed_q <= 1'b0;
      body_q <= 1'b0; ph_q <= PH_NLEN; lbi_q <= '0; acc_q <= '0;
      nleft_q <= '0; vleft_q <= '0;
      res_valid_o <= 1'b0;
    end else begin
      if (res_ready_i) res_valid_o <= fire && emit;
      if (fire) begin
        hdr_idx_q <= hdr_idx_d; rkind_q <= rkind_d; rid_q <= rid_d;
        cleft_q <= cleft_d; coff_q <= coff_d; pad_q <= pad_d; ka_q <= ka_d;
        closed_q <= closed_d; body_q <= body_d; ph_q <= ph_d;
        nleft_q <= nleft_d; vleft_q <= vleft_d;
        if (pair_clr) begin
          lbi_q <= '0; acc_q <= '0;
        end else if (len_upd) begin
          lbi_q <= lbi_d; acc_q <= acc_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_i) res_o <= res;
  end

endmodule

[src/fcgi_queue.sv]
// Two-entry queue between the decoder and the output port.
module fcgi_queue import fcgi_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_valid_i,
  output logic    wr_ready_o,
  input  result_t wr_data_i,
  output logic    rd_valid_o,
  input  logic    rd_ready_i,
  output result_t rd_data_o
);

  result_t    mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

import fcgi_pkg::*;

// Byte-level predictor of the deframer plus the queue of results it expects
class deframe_sb;
  typedef enum logic [1:0] {PH_NAME_LEN, PH_VALUE_LEN, PH_NAME, PH_VALUE} pair_phase_e;

  logic [2:0]  hdr_idx;
  logic [7:0]  rec_kind;
  logic [15:0] rec_id;
  logic [15:0] cont_left;
  logic [15:0] cont_off;
  logic [7:0]  pad_left;
  logic        keep_alive;
  logic        closed;
  logic        in_body;
  pair_phase_e phase;
  logic [1:0]  len_idx;
  logic [31:0] len_acc;
  logic [30:0] name_left;
  logic [30:0] value_left;

  result_t expected_q[$];
  int      errors;

  function new();
    errors = 0;
    hdr_idx = '0; rec_kind = '0; rec_id = '0; cont_left = '0; cont_off = '0;
    pad_left = '0; keep_alive = 1'b0; closed = 1'b0; in_body = 1'b0;
    clear_pair();
  endfunction

  function void clear_pair();
    phase = PH_NAME_LEN;
    len_idx = '0;
    len_acc = '0;
    name_left = '0;
    value_left = '0;
  endfunction

  function void push(kind_e k, logic [7:0] d, logic [30:0] nl, logic [30:0] vl,
                     logic lst, logic ka, logic cl, logic tr);
    result_t r;
    r.kind = k; r.data_byte = d; r.name_length = nl; r.value_length = vl;
    r.last_of_field = lst; r.req_id = rec_id; r.keep_alive_out = ka;
    r.close_conn = cl; r.truncated = tr;
    expected_q.push_back(r);
  endfunction

  // One length byte; returns 1 once the 1- or 4-byte length is complete
  function bit len_byte(logic [7:0] b, output logic [30:0] len);
    len = '0;
    if (len_idx == 0) begin
      if (!b[LongLenBit]) begin
        len = {23'h0, b};
        return 1'b1;
      end
      len_acc = {24'h0, b};
      len_idx = 1;
      return 1'b0;
    end
    len_acc = {len_acc[23:0], b};
    if (len_idx == 3) begin
      len_idx = 0;
      len = len_acc[30:0];
      return 1'b1;
    end
    len_idx++;
    return 1'b0;
  endfunction

  function void params_byte(logic [7:0] b);
    logic [30:0] len;
    case (phase)
      PH_NAME_LEN: begin
        if (len_byte(b, len)) begin
          name_left = len;
          phase = PH_VALUE_LEN;
        end
      end
      PH_VALUE_LEN: begin
        if (len_byte(b, len)) begin
          value_left = len;
          phase = (name_left != 0) ? PH_NAME :
                  ((value_left != 0) ? PH_VALUE : PH_NAME_LEN);
          push(KIND_PAIR_HDR, 8'h0, name_left, value_left, 1'b0, 1'b0, 1'b0, 1'b0);
        end
      end
      PH_NAME: begin
        name_left = name_left - 1;
        if (name_left == 0) phase = (value_left != 0) ? PH_VALUE : PH_NAME_LEN;
        push(KIND_NAME, b, '0, '0, name_left == 0, 1'b0, 1'b0, 1'b0);
      end
      default: begin
        value_left = value_left - 1;
        if (value_left == 0) phase = PH_NAME_LEN;
        push(KIND_VALUE, b, '0, '0, value_left == 0, 1'b0, 1'b0, 1'b0);
      end
    endcase
  endfunction

  function void header_done();
    logic tr;
    cont_off = '0;
    in_body = (cont_left != 0) || (pad_left != 0);
    if (rec_kind == RecBegin) begin
      keep_alive = 1'b0;
      clear_pair();
    end else if (cont_left == 0 && rec_kind == RecParams) begin
      tr = (phase != PH_NAME_LEN) || (len_idx != 0);
      clear_pair();
      push(KIND_PEND, 8'h0, '0, '0, 1'b0, 1'b0, 1'b0, tr);
    end else if (cont_left == 0 && rec_kind == RecStdin) begin
      clear_pair();
      push(KIND_REQ_DONE, 8'h0, '0, '0, 1'b0, keep_alive, !keep_alive, 1'b0);
      if (!keep_alive) closed = 1'b1;
    end
  endfunction

  // Accepted input byte
  function void note_byte(logic [7:0] b);
    if (closed) return;
    if (!in_body) begin
      case (hdr_idx)
        3'd1: rec_kind = b;
        3'd2: rec_id = {b, 8'h00};
        3'd3: rec_id[7:0] = b;
        3'd4: cont_left = {b, 8'h00};
        3'd5: cont_left[7:0] = b;
        3'd6: pad_left = b;
        default: ;
      endcase
      if (hdr_idx == 7) begin
        hdr_idx = 0;
        header_done();
      end else begin
        hdr_idx++;
      end
      return;
    end
    if (cont_left != 0) begin
      if (rec_kind == RecBegin) begin
        if (cont_off == 2) keep_alive = b[KeepConnBit];
      end else if (rec_kind == RecParams) begin
        params_byte(b);
      end else if (rec_kind == RecStdin) begin
        push(KIND_BODY, b, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
      end
      cont_left--;
      cont_off++;
    end else if (pad_left != 0) begin
      pad_left--;
    end
    if (cont_left == 0 && pad_left == 0) in_body = 1'b0;
  endfunction

  function void cmp(string nm, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $error("%s: expected %0h, got %0h", nm, e, a);
      errors++;
    end
  endfunction

  // Accepted output result
  function void check(result_t got);
    result_t e;
    if (expected_q.size() == 0) begin
      $error("unexpected result item, kind %0d", got.kind);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    cmp("kind", e.kind, got.kind);
    cmp("data_byte", e.data_byte, got.data_byte);
    cmp("name_length", e.name_length, got.name_length);
    cmp("value_length", e.value_length, got.value_length);
    cmp("last_of_field", e.last_of_field, got.last_of_field);
    cmp("req_id", e.req_id, got.req_id);
    cmp("keep_alive_out", e.keep_alive_out, got.keep_alive_out);
    cmp("close_conn", e.close_conn, got.close_conn);
    cmp("truncated", e.truncated, got.truncated);
  endfunction
endclass

module testbench;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned LongHold = 400;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = 8'h00;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [2:0]          m_axis_tuser;
  logic                m_axis_tlast;

  deframe_sb   sb = new();
  logic [7:0]  wire_q[$];
  int unsigned n_results = 0;
  int unsigned idle_cycles = 0;
  bit          no_idle = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned rx_gap = 0;

  fastcgi_record_deframer u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .m_axis_tuser, .m_axis_tlast
  );

  always #1 clk_i = ~clk_i;

  // Monitor both sides and count stuck cycles
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind           = kind_e'(m_axis_tuser);
        got.data_byte      = m_axis_tdata[7:0];
        got.name_length    = m_axis_tdata[38:8];
        got.value_length   = m_axis_tdata[69:39];
        got.last_of_field  = m_axis_tlast;
        got.req_id         = m_axis_tdata[85:70];
        got.keep_alive_out = m_axis_tdata[86];
        got.close_conn     = m_axis_tdata[87];
        got.truncated      = m_axis_tdata[88];
        sb.check(got);
        n_results++;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!long_hold_done && n_results >= 100) begin
        rx_gap = LongHold;
        long_hold_done = 1'b1;
      end
      if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(1, 8) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stream building
  task automatic put_record(input logic [7:0] kind, input logic [15:0] id,
                            input logic [7:0] content[$], input logic [7:0] pad);
    wire_q.push_back(8'($urandom_range(0, 255)));
    wire_q.push_back(kind);
    wire_q.push_back(id[15:8]);
    wire_q.push_back(id[7:0]);
    wire_q.push_back(8'(content.size() >> 8));
    wire_q.push_back(8'(content.size()));
    wire_q.push_back(pad);
    wire_q.push_back(8'($urandom_range(0, 255)));
    foreach (content[i]) wire_q.push_back(content[i]);
    repeat (pad) wire_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic put_empty(input logic [7:0] kind, input logic [15:0] id);
    logic [7:0] none[$];
    put_record(kind, id, none, 8'($urandom_range(0, 2)));
  endtask

  task automatic add_len(ref logic [7:0] q[$], input int unsigned len, input bit long_form);
    if (long_form || len > 127) begin
      q.push_back(8'(32'h80 | ((len >> 24) & 32'h7f)));
      q.push_back(8'(len >> 16));
      q.push_back(8'(len >> 8));
      q.push_back(8'(len));
    end else begin
      q.push_back(8'(len));
    end
  endtask

  task automatic put_begin(input logic [15:0] id, input bit keep, input bit short_body);
    logic [7:0] c[$];
    c.push_back(8'($urandom_range(0, 255)));
    c.push_back(8'($urandom_range(0, 255)));
    if (!short_body) begin
      c.push_back({7'($urandom_range(0, 127)), keep});
      repeat (5) c.push_back(8'($urandom_range(0, 255)));
    end
    put_record(RecBegin, id, c, 8'($urandom_range(0, 3)));
  endtask

  // Pair content split over PARAMS records (with occasional STDIN records between), optionally cut, then params end
  task automatic put_params(input logic [15:0] id, input bit cut);
    logic [7:0] pc[$];
    logic [7:0] chunk[$];
    int unsigned nl, vl, n;
    repeat ($urandom_range(1, 3)) begin
      nl = $urandom_range(0, 5);
      vl = $urandom_range(0, 6);
      add_len(pc, nl, $urandom_range(0, 3) == 0);
      add_len(pc, vl, $urandom_range(0, 3) == 0);
      repeat (nl + vl) pc.push_back(8'($urandom_range(0, 255)));
    end
    if (cut) repeat ($urandom_range(1, pc.size() - 1)) void'(pc.pop_back());
    while (pc.size() > 0) begin
      n = $urandom_range(1, pc.size());
      chunk.delete();
      repeat (n) chunk.push_back(pc.pop_front());
      put_record(RecParams, id, chunk, 8'($urandom_range(0, 3)));
      if ($urandom_range(0, 7) == 0) begin
        chunk.delete();
        repeat ($urandom_range(1, 3)) chunk.push_back(8'($urandom_range(0, 255)));
        put_record(RecStdin, id, chunk, 8'd0);
      end
    end
    put_empty(RecParams, id);
  endtask

  task automatic put_request(input logic [15:0] id, input bit keep, input bit short_begin);
    logic [7:0] c[$];
    logic [7:0] t;
    put_begin(id, keep, short_begin);
    if ($urandom_range(0, 4) == 0) begin
      do t = 8'($urandom_range(0, 255));
      while (t == RecBegin || t == RecParams || t == RecStdin);
      repeat ($urandom_range(0, 4)) c.push_back(8'($urandom_range(0, 255)));
      put_record(t, id, c, 8'($urandom_range(0, 2)));
    end
    put_params(id, $urandom_range(0, 7) == 0);
    repeat ($urandom_range(0, 2)) begin
      c.delete();
      repeat ($urandom_range(1, 8)) c.push_back(8'($urandom_range(0, 255)));
      put_record(RecStdin, id, c, 8'($urandom_range(0, 3)));
    end
    put_empty(RecStdin, id);
  endtask

  task automatic build_stream();
    logic [7:0] c[$];
    // Directed: extreme ids, zero-length pair, maximum 31-bit lengths cut off,
    // long padding, skipped record types
    put_begin(16'hffff, 1'b1, 1'b0);
    c = '{8'h00, 8'h00, 8'h81, 8'h80, 8'h00, 8'h00, 8'h02, 8'hab, 8'hff, 8'h00};
    put_record(RecParams, 16'hffff, c, 8'd255);
    put_empty(RecParams, 16'hffff);
    c = '{8'hff, 8'hff, 8'hff, 8'hff, 8'h05, 8'h41};
    put_record(RecParams, 16'h0000, c, 8'd0);
    put_empty(RecParams, 16'h0000);
    c = '{8'h7f, 8'h7f};
    put_record(8'hff, 16'h1234, c, 8'd1);
    put_record(8'h00, 16'h1234, c, 8'd0);
    c = '{8'h00, 8'hff, 8'h80};
    put_record(RecStdin, 16'h0000, c, 8'd0);
    put_empty(RecStdin, 16'h0000);
    // Random requests, all keeping the connection
    while (wire_q.size() < 800)
      put_request(16'($urandom_range(0, 65535)), 1'b1, 1'b0);
    // Last request: short begin body drops keep-alive, so the block closes
    put_request(16'($urandom_range(0, 65535)), 1'b1, 1'b1);
    repeat (20) wire_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic send_byte(input logic [7:0] b);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  initial begin
    int unsigned total, pause_at;
    build_stream();
    total = wire_q.size();
    pause_at = total / 2;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int unsigned i = 0; i < total; i++) begin
      if (i * 10 >= total * 8) no_idle = 1'b1;
      if (i == pause_at) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (sb.expected_q.size() != 0) @(posedge clk_i);
      end
      send_byte(wire_q[i]);
      if (!no_idle && $urandom_range(0, 7) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

[files.f]
src/fcgi_pkg.sv
src/fcgi_front.sv
src/fcgi_queue.sv
src/fastcgi_record_deframer.sv
tb/sv/testbench.sv
